/* design/csv_field_splitter_core_defines.svh */
// Assertion macros shared by the CSV field splitter RTL.
`ifndef CSV_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_FIELD_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csv field splitter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSVFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csv field splitter: next-cycle check failed");

`endif

/* design/csvfs_pkg.sv */
// Package with the types and character codes of the CSV field splitter.
`timescale 1ns / 1ps
`default_nettype none

package csvfs_pkg;

    localparam int FIELD_W = 4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic               has_byte;
        logic [7:0]         out_byte;
        logic [FIELD_W-1:0] field_number;
        logic               field_end;
        logic               record_end;
        logic               too_many_fields;
    } t_result;

    typedef struct packed {
        logic               quote_parity;
        logic [FIELD_W-1:0] current_field;
    } t_parse_status;

endpackage

`default_nettype wire

/* design/csvfs_in_stage.sv */
// Input register that captures one raw byte per transfer.
`timescale 1ns / 1ps
`default_nettype none

module csvfs_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

/* design/csvfs_parser.sv */
// Field and quote state with the per-byte splitting logic.
`timescale 1ns / 1ps
`default_nettype none

module csvfs_parser #(
    parameter int NUM_FIELDS = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire logic [7:0]           i_byte,
    output csvfs_pkg::t_result        o_result,
    output csvfs_pkg::t_parse_status  o_status
);

    import csvfs_pkg::*;

    localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS - 1);

    logic               r_quote_parity,    n_quote_parity;
    logic [FIELD_W-1:0] r_current_field,   n_current_field;
    logic               r_field_has_bytes, n_field_has_bytes;
    logic               r_held_valid,      n_held_valid;
    logic [7:0]         r_held_byte,       n_held_byte;
    logic               r_last_kept_quote, n_last_kept_quote;
    logic               r_overflow_seen,   n_overflow_seen;

    logic is_quote;
    logic is_lf;
    logic is_cr;
    logic is_end;
    logic parity_next;

    assign is_quote    = (i_byte == CH_QUOTE);
    assign is_lf       = (i_byte == CH_LF);
    assign is_cr       = (i_byte == CH_CR);
    assign parity_next = r_quote_parity ^ is_quote;
    assign is_end      = ((i_byte == CH_COMMA) && !parity_next) || is_lf;

    always_comb begin
        n_quote_parity    = parity_next;
        n_current_field   = r_current_field;
        n_field_has_bytes = r_field_has_bytes;
        n_held_valid      = r_held_valid;
        n_held_byte       = r_held_byte;
        n_last_kept_quote = r_last_kept_quote;
        n_overflow_seen   = r_overflow_seen;

        o_result              = '0;
        o_result.field_number = r_current_field;

        if (is_end) begin
            // The held byte is the last one of the field, so a quote there is dropped.
            if (r_held_valid && (r_held_byte != CH_QUOTE)) begin
                o_result.has_byte = 1'b1;
                o_result.out_byte = r_held_byte;
            end
            o_result.field_end = 1'b1;
            n_field_has_bytes  = 1'b0;
            n_held_valid       = 1'b0;
            n_held_byte        = '0;
            n_last_kept_quote  = 1'b0;
            if (is_lf) begin
                o_result.record_end = 1'b1;
            end else if (r_current_field >= LAST_FIELD) begin
                n_overflow_seen = 1'b1;
                n_current_field = LAST_FIELD;
            end else begin
                n_current_field = r_current_field + FIELD_W'(1);
            end
        end else if (!is_cr) begin
            // A held quote right after a kept quote is dropped.
            if (r_held_valid) begin
                if (r_held_byte != CH_QUOTE) begin
                    o_result.has_byte = 1'b1;
                    o_result.out_byte = r_held_byte;
                    n_last_kept_quote = 1'b0;
                end else if (!r_last_kept_quote) begin
                    o_result.has_byte = 1'b1;
                    o_result.out_byte = r_held_byte;
                    n_last_kept_quote = 1'b1;
                end
            end
            // A leading quote is dropped at once and never held.
            if (is_quote && !r_field_has_bytes) begin
                n_held_valid = 1'b0;
            end else begin
                n_held_valid = 1'b1;
                n_held_byte  = i_byte;
            end
            n_field_has_bytes = 1'b1;
        end

        o_result.too_many_fields = n_overflow_seen;

        if (is_lf) begin
            n_quote_parity  = 1'b0;
            n_current_field = '0;
            n_overflow_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_parity    <= 1'b0;
            r_current_field   <= '0;
            r_field_has_bytes <= 1'b0;
            r_held_valid      <= 1'b0;
            r_held_byte       <= '0;
            r_last_kept_quote <= 1'b0;
            r_overflow_seen   <= 1'b0;
        end else if (i_advance) begin
            r_quote_parity    <= n_quote_parity;
            r_current_field   <= n_current_field;
            r_field_has_bytes <= n_field_has_bytes;
            r_held_valid      <= n_held_valid;
            r_held_byte       <= n_held_byte;
            r_last_kept_quote <= n_last_kept_quote;
            r_overflow_seen   <= n_overflow_seen;
        end
    end

    assign o_status.quote_parity  = r_quote_parity;
    assign o_status.current_field = r_current_field;

endmodule

`default_nettype wire

/* design/csvfs_out_stage.sv */
// Result register that holds one result until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module csvfs_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire csvfs_pkg::t_result  i_result,
    input  wire logic                i_ready,
    output logic                     o_can_take,
    output logic                     o_valid,
    output csvfs_pkg::t_result       o_result
);

    import csvfs_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* design/csv_field_splitter_core.sv */
// Top level of the CSV field splitter: input register, parser and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_field_splitter_core_defines.svh"

// The splitter takes one raw byte of CSV text per transfer and returns exactly
// one result per byte, in order. A byte is captured in an input register, run
// through the field and quote logic, and the result lands in an output
// register, so the block sustains one byte per clock while the output is not
// stalled; a result is offered once its byte has passed through the input
// register and the output register. The only loop is the parser's small state
// update. Because the last byte of a field may be a quote that has to be dropped,
// each kept byte is held back and reported with the result of the following byte,
// or together with field_end when a comma outside quotes or a newline closes the
// field. Carriage returns give an idle result. A comma past field NUM_FIELDS-1
// keeps the field index at its last value and raises too_many_fields until the
// record's newline result. Both sides use valid and ready; a stalled result
// holds the output register while the input register can still take one more
// byte, and o_ready drops only when both registers are full.
module csv_field_splitter_core #(
    parameter int NUM_FIELDS = 11
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_in_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_has_byte,
    output logic [7:0]                         o_out_byte,
    output logic [csvfs_pkg::FIELD_W-1:0]      o_field_number,
    output logic                               o_field_end,
    output logic                               o_record_end,
    output logic                               o_too_many_fields
);

    import csvfs_pkg::*;

    localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS - 1);

    logic          stage_valid;
    logic [7:0]    stage_byte;
    logic          out_can_take;
    logic          advance;
    t_result       step_result;
    t_result       held_result;
    t_parse_status parse_status;

    // A byte moves from the input register into the parser whenever the
    // result register is empty or its current result is being transferred.
    assign advance = stage_valid && out_can_take;

    csvfs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_byte    (i_in_byte),
        .i_advance (advance),
        .o_ready   (o_ready),
        .o_valid   (stage_valid),
        .o_byte    (stage_byte)
    );

    csvfs_parser #(
        .NUM_FIELDS (NUM_FIELDS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (stage_byte),
        .o_result  (step_result),
        .o_status  (parse_status)
    );

    csvfs_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (step_result),
        .i_ready    (i_ready),
        .o_can_take (out_can_take),
        .o_valid    (o_valid),
        .o_result   (held_result)
    );

    assign o_has_byte        = held_result.has_byte;
    assign o_out_byte        = held_result.out_byte;
    assign o_field_number    = held_result.field_number;
    assign o_field_end       = held_result.field_end;
    assign o_record_end      = held_result.record_end;
    assign o_too_many_fields = held_result.too_many_fields;

    // Backpressure reaches the input side only when both registers are full.
    `CSVFS_ASSERT_IMP(a_ready_only_when_full, i_clk, i_rst_n,
        stage_valid && o_valid && !i_ready, !o_ready)

    // A newline leaves the next record with even parity and field zero.
    `CSVFS_ASSERT_NXT(a_newline_clears, i_clk, i_rst_n,
        advance && (stage_byte == CH_LF),
        (parse_status.current_field == '0) && !parse_status.quote_parity)

    // The field index never leaves the configured range.
    `CSVFS_ASSERT_IMP(a_field_in_range, i_clk, i_rst_n,
        1'b1, parse_status.current_field <= LAST_FIELD)

endmodule

`default_nettype wire
